// ===== rtl/core/recursive_ticket_rw_lock_top_defines.svh =====
// Assertion macros shared by the lock checker.
`ifndef RECURSIVE_TICKET_RW_LOCK_TOP_DEFINES_SVH
`define RECURSIVE_TICKET_RW_LOCK_TOP_DEFINES_SVH

// Clocked assertion, disabled while in reset.
`define RTRWL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication on an output beat being presented.
`define RTRWL_ASSERT_OUT(label, cond, msg) \
    `RTRWL_ASSERT(label, (m_tvalid && (cond)) |-> 1'b1 && (cond), msg)

`endif

// ===== rtl/core/rtrwl_pkg.sv =====
// Types and constants for the recursive ticket reader/writer lock.
`timescale 1ns / 1ps
package rtrwl_pkg;

    localparam int NUM_CPUS    = 16;
    localparam int TICKET_BITS = 16;
    localparam int DEPTH_BITS  = 8;
    localparam int CPU_W       = 4;
    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 4;
    localparam int READER_W    = $clog2(NUM_CPUS + 1);

    localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX  = '1;
    localparam logic [READER_W-1:0]    READER_MAX = READER_W'(NUM_CPUS);

    typedef enum logic [MODE_W-1:0] {
        MODE_ACQUIRE      = 3'd0,
        MODE_POLL         = 3'd1,
        MODE_RELEASE      = 3'd2,
        MODE_TRY_READ     = 3'd3,
        MODE_READ_RELEASE = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED        = 4'd0,
        ST_WAITING        = 4'd1,
        ST_DEPTH_LIMIT    = 4'd2,
        ST_RELEASED       = 4'd3,
        ST_STILL_HELD     = 4'd4,
        ST_NOT_OWNER      = 4'd5,
        ST_READ_GRANTED   = 4'd6,
        ST_READ_REFUSED   = 4'd7,
        ST_READ_RELEASED  = 4'd8,
        ST_READ_UNDERFLOW = 4'd9
    } status_t;

    typedef struct packed {
        logic [TICKET_BITS-1:0] ticket;
        logic [CPU_W-1:0]       cpu_id;
        logic [MODE_W-1:0]      mode;
    } req_t;

    typedef struct packed {
        logic [READER_W-1:0]    readers_out;
        logic [DEPTH_BITS-1:0]  depth_out;
        logic [TICKET_BITS-1:0] ticket_out;
        logic [STATUS_W-1:0]    status;
    } rsp_t;

endpackage

// ===== rtl/core/rtrwl_core.sv =====
// Lock state registers and the per-request decision logic.
`timescale 1ns / 1ps
module rtrwl_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  rtrwl_pkg::req_t req,
    output rtrwl_pkg::rsp_t rsp
);
    import rtrwl_pkg::*;

    logic [TICKET_BITS-1:0] next_tk_reg, next_tk_next;
    logic [TICKET_BITS-1:0] serving_reg, serving_next;
    logic                   owner_valid_reg, owner_valid_next;
    logic [CPU_W-1:0]       owner_cpu_reg, owner_cpu_next;
    logic [DEPTH_BITS-1:0]  depth_reg, depth_next;
    logic [READER_W-1:0]    readers_reg, readers_next;

    logic [CPU_W-1:0] cpu;
    logic             is_owner;
    logic             serving_hit;
    status_t          status;
    logic [TICKET_BITS-1:0] tk_out;

    always_comb
    begin
        cpu = ({1'b0, req.cpu_id} >= (CPU_W + 1)'(NUM_CPUS)) ? '0 : req.cpu_id;
        is_owner = owner_valid_reg && (owner_cpu_reg == cpu) && (depth_reg != '0);
        serving_hit = (req.ticket == serving_reg);

        next_tk_next     = next_tk_reg;
        serving_next     = serving_reg;
        owner_valid_next = owner_valid_reg;
        owner_cpu_next   = owner_cpu_reg;
        depth_next       = depth_reg;
        readers_next     = readers_reg;
        tk_out           = req.ticket;
        status           = ST_NOT_OWNER;

        case (req.mode)
            MODE_ACQUIRE:
            begin
                if (is_owner)
                begin
                    if (depth_reg == DEPTH_MAX)
                    begin
                        status = ST_DEPTH_LIMIT;
                    end
                    else
                    begin
                        depth_next = depth_reg + 1'b1;
                        status     = ST_GRANTED;
                    end
                end
                else
                begin
                    next_tk_next = next_tk_reg + 1'b1;
                    tk_out       = next_tk_reg;
                    if (!owner_valid_reg && readers_reg == '0 && serving_reg == next_tk_reg)
                    begin
                        owner_valid_next = 1'b1;
                        owner_cpu_next   = cpu;
                        depth_next       = DEPTH_BITS'(1);
                        status           = ST_GRANTED;
                    end
                    else
                    begin
                        status = ST_WAITING;
                    end
                end
            end
            MODE_POLL:
            begin
                if (is_owner && serving_hit)
                begin
                    status = ST_GRANTED;
                end
                else if (serving_hit && !owner_valid_reg && readers_reg == '0 &&
                         next_tk_reg != serving_reg)
                begin
                    owner_valid_next = 1'b1;
                    owner_cpu_next   = cpu;
                    depth_next       = DEPTH_BITS'(1);
                    status           = ST_GRANTED;
                end
                else
                begin
                    status = ST_WAITING;
                end
            end
            MODE_RELEASE:
            begin
                if (is_owner && depth_reg > DEPTH_BITS'(1))
                begin
                    depth_next = depth_reg - 1'b1;
                    status     = ST_STILL_HELD;
                end
                else if (is_owner)
                begin
                    depth_next       = '0;
                    owner_valid_next = 1'b0;
                    owner_cpu_next   = '0;
                    serving_next     = serving_reg + 1'b1;
                    status           = ST_RELEASED;
                end
                else
                begin
                    status = ST_NOT_OWNER;
                end
            end
            MODE_TRY_READ:
            begin
                if (next_tk_reg != serving_reg || readers_reg >= READER_MAX)
                begin
                    status = ST_READ_REFUSED;
                end
                else
                begin
                    readers_next = readers_reg + 1'b1;
                    status       = ST_READ_GRANTED;
                end
            end
            MODE_READ_RELEASE:
            begin
                if (readers_reg == '0)
                begin
                    status = ST_READ_UNDERFLOW;
                end
                else
                begin
                    readers_next = readers_reg - 1'b1;
                    status       = ST_READ_RELEASED;
                end
            end
            default:
            begin
                status = ST_NOT_OWNER;
            end
        endcase

        rsp.status      = status;
        rsp.ticket_out  = tk_out;
        rsp.depth_out   = depth_next;
        rsp.readers_out = readers_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_tk_reg     <= '0;
            serving_reg     <= '0;
            owner_valid_reg <= 1'b0;
            owner_cpu_reg   <= '0;
            depth_reg       <= '0;
            readers_reg     <= '0;
        end
        else if (fire)
        begin
            next_tk_reg     <= next_tk_next;
            serving_reg     <= serving_next;
            owner_valid_reg <= owner_valid_next;
            owner_cpu_reg   <= owner_cpu_next;
            depth_reg       <= depth_next;
            readers_reg     <= readers_next;
        end
    end

endmodule

// ===== rtl/core/recursive_ticket_rw_lock_top.sv =====
// Top level of the recursive ticket reader/writer lock.
// Requests are registered in req_reg, results in rsp_reg, shown on m_tvalid.
// Throughput: one request per cycle while m_tready stays high.
// Each beat sees the lock state left by the previous beat (single state update stage).
// Reset: rst_n (async, active low) clears tickets, owner, depth, readers and valid flags.
`timescale 1ns / 1ps
module recursive_ticket_rw_lock_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // mode[2:0], cpu_id[6:3], ticket[22:7], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // status[3:0], ticket_out[19:4], depth_out[27:20],
                                   // readers_out[32:28], zero pad
);
    import rtrwl_pkg::*;

    localparam int REQ_W = $bits(req_t);
    localparam int RSP_W = $bits(rsp_t);

    req_t req_reg;
    logic in_valid_reg;
    rsp_t rsp, rsp_reg;
    logic out_valid_reg;
    logic advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            req_reg <= req_t'(s_tdata[REQ_W-1:0]);
        end
        if (advance)
        begin
            rsp_reg <= rsp;
        end
    end

    rtrwl_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .req   (req_reg),
        .rsp   (rsp)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(40 - RSP_W){1'b0}}, rsp_reg};

endmodule

// ===== rtl/core/rtrwl_checker.sv =====
// Port-level checker for the lock top level, bound into it.
`timescale 1ns / 1ps
`include "recursive_ticket_rw_lock_top_defines.svh"
module rtrwl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    import rtrwl_pkg::*;

    logic [STATUS_W-1:0] st;
    logic [7:0]          dep;
    logic [4:0]          rdr;

    assign st  = m_tdata[3:0];
    assign dep = m_tdata[27:20];
    assign rdr = m_tdata[32:28];

    `RTRWL_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")
    `RTRWL_ASSERT(a_latency, s_tvalid && s_tready && s_tdata[23] == 1'b0 |-> ##2 m_tvalid, "accepted beat produced no result")
    `RTRWL_ASSERT(a_read_cnt, m_tvalid && st == ST_READ_GRANTED |-> rdr != 5'd0 && rdr <= 5'd16, "read grant with bad reader count")
    `RTRWL_ASSERT(a_depth, m_tvalid && (st == ST_RELEASED) |-> dep == 8'd0, "release left nonzero depth")

endmodule

bind recursive_ticket_rw_lock_top rtrwl_checker u_rtrwl_checker (.*);

// ===== tb/tb_recursive_ticket_rw_lock_top.sv =====
// Recursive ticket RW lock testbench: directed table, random traffic, deep recursion, sweep.
`timescale 1ns / 1ps
module tb_recursive_ticket_rw_lock_top;
    import rtrwl_pkg::*;

    localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 20;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    recursive_ticket_rw_lock_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // shadow lock state
    logic [TICKET_BITS-1:0] nxt_tk;
    logic [TICKET_BITS-1:0] srv_tk;
    logic                   own_v;
    logic [CPU_W-1:0]       own_cpu;
    logic [DEPTH_BITS-1:0]  own_depth;
    logic [READER_W-1:0]    rd_cnt;

    rsp_t rsp_due [$];
    int   mismatch_cnt = 0;
    int   items_sent = 0;
    int   cycle_cnt = 0;
    bit   no_idle = 1'b0;

    typedef struct {
        logic [MODE_W-1:0]      md;
        logic [CPU_W-1:0]       cpu;
        logic [TICKET_BITS-1:0] tk;
        bit                     chk;
        logic [STATUS_W-1:0]    st;
        logic [TICKET_BITS-1:0] tk_o;
        logic [DEPTH_BITS-1:0]  dep;
        logic [READER_W-1:0]    rd;
    } dir_row_t;

    // chk = 0 rows are checked against the predictor only
    dir_row_t dir_rows [26] = '{
        '{MODE_ACQUIRE,      4'd3,  16'hFFFF, 1'b1, ST_GRANTED,        16'h0000, 8'd1, 5'd0},
        '{MODE_ACQUIRE,      4'd3,  16'h0000, 1'b1, ST_GRANTED,        16'h0000, 8'd2, 5'd0},
        '{MODE_POLL,         4'd3,  16'h0000, 1'b1, ST_GRANTED,        16'h0000, 8'd2, 5'd0},
        '{MODE_ACQUIRE,      4'd9,  16'h1234, 1'b1, ST_WAITING,        16'h0001, 8'd2, 5'd0},
        '{MODE_POLL,         4'd9,  16'h0001, 1'b1, ST_WAITING,        16'h0001, 8'd2, 5'd0},
        '{MODE_TRY_READ,     4'd5,  16'hFFFF, 1'b1, ST_READ_REFUSED,   16'hFFFF, 8'd2, 5'd0},
        '{MODE_RELEASE,      4'd9,  16'h0001, 1'b1, ST_NOT_OWNER,      16'h0001, 8'd2, 5'd0},
        '{MODE_RELEASE,      4'd3,  16'h0000, 1'b1, ST_STILL_HELD,     16'h0000, 8'd1, 5'd0},
        '{MODE_RELEASE,      4'd3,  16'h0000, 1'b1, ST_RELEASED,       16'h0000, 8'd0, 5'd0},
        '{MODE_POLL,         4'd9,  16'h0001, 1'b1, ST_GRANTED,        16'h0001, 8'd1, 5'd0},
        '{MODE_POLL,         4'd3,  16'h0001, 1'b0, ST_GRANTED,        16'h0000, 8'd0, 5'd0},
        '{MODE_RELEASE,      4'd9,  16'h0001, 1'b1, ST_RELEASED,       16'h0001, 8'd0, 5'd0},
        '{MODE_TRY_READ,     4'd15, 16'h0000, 1'b1, ST_READ_GRANTED,   16'h0000, 8'd0, 5'd1},
        '{MODE_ACQUIRE,      4'd0,  16'h5555, 1'b1, ST_WAITING,        16'h0002, 8'd0, 5'd1},
        '{MODE_TRY_READ,     4'd1,  16'h0002, 1'b0, ST_GRANTED,        16'h0000, 8'd0, 5'd0},
        '{MODE_POLL,         4'd0,  16'h0002, 1'b1, ST_WAITING,        16'h0002, 8'd0, 5'd1},
        '{MODE_READ_RELEASE, 4'd15, 16'h0000, 1'b1, ST_READ_RELEASED,  16'h0000, 8'd0, 5'd0},
        '{MODE_READ_RELEASE, 4'd1,  16'hFFFF, 1'b1, ST_READ_UNDERFLOW, 16'hFFFF, 8'd0, 5'd0},
        '{MODE_POLL,         4'd0,  16'h0002, 1'b1, ST_GRANTED,        16'h0002, 8'd1, 5'd0},
        '{MODE_RSVD5,        4'd0,  16'hAAAA, 1'b1, ST_NOT_OWNER,      16'hAAAA, 8'd1, 5'd0},
        '{MODE_RSVD6,        4'd15, 16'h5555, 1'b1, ST_NOT_OWNER,      16'h5555, 8'd1, 5'd0},
        '{MODE_RSVD7,        4'd7,  16'h0000, 1'b1, ST_NOT_OWNER,      16'h0000, 8'd1, 5'd0},
        '{MODE_RELEASE,      4'd0,  16'h0002, 1'b1, ST_RELEASED,       16'h0002, 8'd0, 5'd0},
        '{MODE_POLL,         4'd4,  16'h0003, 1'b0, ST_GRANTED,        16'h0000, 8'd0, 5'd0},
        '{MODE_TRY_READ,     4'd0,  16'h0003, 1'b1, ST_READ_GRANTED,   16'h0003, 8'd0, 5'd1},
        '{MODE_READ_RELEASE, 4'd0,  16'h0003, 1'b1, ST_READ_RELEASED,  16'h0003, 8'd0, 5'd0}
    };

    function automatic rsp_t lock_predict(input req_t r);
        rsp_t p;
        logic owner_hit;
        logic at_head;
        p.status     = ST_NOT_OWNER;
        p.ticket_out = r.ticket;
        owner_hit    = own_v && own_cpu == r.cpu_id && own_depth != '0;
        case (r.mode)
            MODE_ACQUIRE:
                if (owner_hit)
                begin
                    if (own_depth == DEPTH_MAX)
                        p.status = ST_DEPTH_LIMIT;
                    else
                    begin
                        own_depth = own_depth + 1'b1;
                        p.status  = ST_GRANTED;
                    end
                end
                else
                begin
                    p.ticket_out = nxt_tk;
                    at_head      = !own_v && rd_cnt == '0 && srv_tk == nxt_tk;
                    nxt_tk       = nxt_tk + 1'b1;
                    if (at_head)
                    begin
                        own_v     = 1'b1;
                        own_cpu   = r.cpu_id;
                        own_depth = 8'd1;
                        p.status  = ST_GRANTED;
                    end
                    else
                        p.status = ST_WAITING;
                end
            MODE_POLL:
            begin
                at_head = r.ticket == srv_tk;
                if (owner_hit && at_head)
                    p.status = ST_GRANTED;
                else if (at_head && !own_v && rd_cnt == '0 && nxt_tk != srv_tk)
                begin
                    own_v     = 1'b1;
                    own_cpu   = r.cpu_id;
                    own_depth = 8'd1;
                    p.status  = ST_GRANTED;
                end
                else
                    p.status = ST_WAITING;
            end
            MODE_RELEASE:
                if (owner_hit && own_depth > 8'd1)
                begin
                    own_depth = own_depth - 1'b1;
                    p.status  = ST_STILL_HELD;
                end
                else if (owner_hit)
                begin
                    own_depth = '0;
                    own_v     = 1'b0;
                    own_cpu   = '0;
                    srv_tk    = srv_tk + 1'b1;
                    p.status  = ST_RELEASED;
                end
            MODE_TRY_READ:
                if (nxt_tk != srv_tk || rd_cnt >= READER_MAX)
                    p.status = ST_READ_REFUSED;
                else
                begin
                    rd_cnt   = rd_cnt + 1'b1;
                    p.status = ST_READ_GRANTED;
                end
            MODE_READ_RELEASE:
                if (rd_cnt == '0)
                    p.status = ST_READ_UNDERFLOW;
                else
                begin
                    rd_cnt   = rd_cnt - 1'b1;
                    p.status = ST_READ_RELEASED;
                end
            default:
                p.status = ST_NOT_OWNER;
        endcase
        p.depth_out   = own_depth;
        p.readers_out = rd_cnt;
        return p;
    endfunction

    function automatic logic [CPU_W-1:0] rnd_cpu();
        return CPU_W'($urandom_range(0, NUM_CPUS - 1));
    endfunction

    function automatic logic [TICKET_BITS-1:0] rnd_tk();
        return TICKET_BITS'($urandom);
    endfunction

    // entered and left at a rising edge
    task automatic send_req(input req_t r, input bit use_fixed, input rsp_t fixed,
                            output rsp_t p);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r};
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        p = lock_predict(r);
        rsp_due.push_back(use_fixed ? fixed : p);
        items_sent++;
    endtask

    task automatic issue(input logic [MODE_W-1:0] md, input logic [CPU_W-1:0] cpu,
                         input logic [TICKET_BITS-1:0] tk, output rsp_t p);
        req_t r;
        r.mode   = md;
        r.cpu_id = cpu;
        r.ticket = tk;
        send_req(r, 1'b0, '0, p);
    endtask

    // well-formed steps back to no owner, no readers, no queued tickets
    task automatic drain_lock();
        rsp_t p;
        while (own_v || rd_cnt != '0 || nxt_tk != srv_tk)
        begin
            if (rd_cnt != '0)
                issue(MODE_READ_RELEASE, rnd_cpu(), rnd_tk(), p);
            else if (own_v)
                issue(MODE_RELEASE, own_cpu, rnd_tk(), p);
            else
                issue(MODE_POLL, rnd_cpu(), srv_tk, p);
        end
    endtask

    task automatic writer_episode();
        rsp_t p;
        logic [TICKET_BITS-1:0] held_tk [NUM_CPUS];
        bit queued [NUM_CPUS];
        int n_q;
        int steps;
        int k;
        logic [CPU_W-1:0] c;
        drain_lock();
        n_q = 0;
        foreach (queued[i]) queued[i] = 1'b0;
        repeat ($urandom_range(1, 5))
        begin
            do c = rnd_cpu(); while (queued[c]);
            issue(MODE_ACQUIRE, c, rnd_tk(), p);
            if (p.status == ST_WAITING)
            begin
                queued[c]  = 1'b1;
                held_tk[c] = p.ticket_out;
                n_q++;
            end
        end
        steps = 0;
        while ((own_v || n_q > 0) && steps < 60)
        begin
            steps++;
            k = $urandom_range(0, 9);
            if (own_v && k < 4)
                issue(MODE_RELEASE, own_cpu, rnd_tk(), p);
            else if (own_v && k < 6)
                issue(MODE_ACQUIRE, own_cpu, rnd_tk(), p);
            else if (k == 6)
                issue($urandom_range(0, 1) ? MODE_TRY_READ : MODE_READ_RELEASE,
                      rnd_cpu(), rnd_tk(), p);
            else if (k == 7)
                issue(MODE_RELEASE, rnd_cpu(), rnd_tk(), p);
            else if (n_q > 0)
            begin
                do c = rnd_cpu(); while (!queued[c]);
                issue(MODE_POLL, c, ($urandom_range(0, 3) == 0) ? rnd_tk() : held_tk[c], p);
                if (p.status == ST_GRANTED)
                begin
                    queued[c] = 1'b0;
                    n_q--;
                end
            end
        end
        drain_lock();
    endtask

    task automatic reader_episode();
        rsp_t p;
        int k;
        drain_lock();
        if ($urandom_range(0, 2) == 0)
            repeat (NUM_CPUS + 2) issue(MODE_TRY_READ, rnd_cpu(), rnd_tk(), p);
        repeat ($urandom_range(1, 20))
        begin
            k = $urandom_range(0, 9);
            if (k < 6)
                issue(MODE_TRY_READ, rnd_cpu(), rnd_tk(), p);
            else if (k < 9)
                issue(MODE_READ_RELEASE, rnd_cpu(), rnd_tk(), p);
            else
                issue(MODE_ACQUIRE, rnd_cpu(), rnd_tk(), p);
        end
        drain_lock();
        issue(MODE_READ_RELEASE, rnd_cpu(), rnd_tk(), p);
    endtask

    task automatic noise_burst();
        rsp_t p;
        repeat ($urandom_range(3, 12))
            issue(MODE_W'($urandom_range(MODE_ACQUIRE, MODE_RSVD7)), rnd_cpu(), rnd_tk(), p);
    endtask

    task automatic deep_recursion();
        rsp_t p;
        logic [CPU_W-1:0] c;
        drain_lock();
        c = rnd_cpu();
        issue(MODE_ACQUIRE, c, rnd_tk(), p);
        do issue(MODE_ACQUIRE, c, rnd_tk(), p); while (p.status != ST_DEPTH_LIMIT);
        repeat (2) issue(MODE_ACQUIRE, c, rnd_tk(), p);
        issue(MODE_POLL, c, srv_tk, p);
        drain_lock();
    endtask

    // walk both ticket counters forward with acquire/release pairs
    task automatic sweep_tickets(input logic [TICKET_BITS-1:0] stop_at);
        rsp_t p;
        logic [CPU_W-1:0] c;
        drain_lock();
        while (nxt_tk != stop_at)
        begin
            c = rnd_cpu();
            issue(MODE_ACQUIRE, c, rnd_tk(), p);
            issue(MODE_RELEASE, c, rnd_tk(), p);
        end
    endtask

    task automatic random_traffic(input int n_items);
        int base;
        int k;
        base = items_sent;
        while (items_sent - base < n_items)
        begin
            no_idle = ($urandom_range(0, 7) == 0);
            k = $urandom_range(0, 9);
            if (k < 5)
                writer_episode();
            else if (k < 7)
                reader_episode();
            else
                noise_burst();
        end
        no_idle = 1'b0;
    endtask

    task automatic cmp_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk)
    begin : rsp_check
        rsp_t want;
        rsp_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = rsp_t'(m_tdata[32:0]);
            if (rsp_due.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
                mismatch_cnt++;
            end
            else
            begin
                want = rsp_due.pop_front();
                cmp_field("status", want.status, got.status);
                cmp_field("ticket_out", want.ticket_out, got.ticket_out);
                cmp_field("depth_out", want.depth_out, got.depth_out);
                cmp_field("readers_out", want.readers_out, got.readers_out);
            end
        end
    end

    initial
    begin : sink
        int stall;
        bit took;
        m_tready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                took = m_tvalid;
                @(posedge clk);
            end while (!took);
        end
    end

    initial
    begin : stimulus
        req_t r;
        rsp_t want;
        rsp_t p;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        nxt_tk    = '0;
        srv_tk    = '0;
        own_v     = 1'b0;
        own_cpu   = '0;
        own_depth = '0;
        rd_cnt    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            r.mode           = dir_rows[i].md;
            r.cpu_id         = dir_rows[i].cpu;
            r.ticket         = dir_rows[i].tk;
            want.status      = dir_rows[i].st;
            want.ticket_out  = dir_rows[i].tk_o;
            want.depth_out   = dir_rows[i].dep;
            want.readers_out = dir_rows[i].rd;
            send_req(r, dir_rows[i].chk, want, p);
        end

        random_traffic(250);
        deep_recursion();
        no_idle = 1'b1;
        sweep_tickets(nxt_tk + 16'd40);
        no_idle = 1'b0;
        random_traffic(250);

        s_tvalid <= 1'b0;
        while (rsp_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
